// ===== sv/assert_macros.svh =====
// assertion macros used by per_element_latest_hit_select
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds in this cycle -> consequent holds in the same cycle
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent holds in this cycle -> consequent holds in the next cycle
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/pels_pkg.sv =====
// shared types and constants of the per-element latest hit select block
// no dependencies
package pels_pkg;

  localparam int NUM_ELEMENTS_DEF = 256;
  localparam int MAX_HITS         = 4096;

  // field widths
  localparam int DET_W  = 8;
  localparam int ELE_W  = 8;
  localparam int TIME_W = 16;
  localparam int POS_W  = 12;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  // table word: {position, time}
  localparam int MEM_W = POS_W + TIME_W;

  // presence bits are kept in groups of sixteen
  localparam int GROUP_W    = 16;
  localparam int GROUP_BITS = 4;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam logic ADDR_DETECTOR_SELECT = 1'b0;

  typedef struct packed {
    logic found;  // some bit set
    logic more;   // a set bit above the first one
  } pick_t;

endpackage

// ===== sv/pels_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read during write to the same entry returns old data
module pels_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pels_pick.sv =====
// lowest set bit of a vector, with flags for any bit and a second bit
// depends on pels_pkg
module pels_pick #(
  parameter int WIDTH = 16,
  parameter int IDX_W = 4
) (
  input  logic [WIDTH-1:0] vec,
  output logic [IDX_W-1:0] idx,
  output pels_pkg::pick_t  res
);
  import pels_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    res.found = |vec;
    // clearing the lowest set bit leaves something only if at least two were set
    res.more  = |(vec & (vec - WIDTH'(1)));
  end

endmodule

// ===== sv/per_element_latest_hit_select.sv =====
// per-element latest hit select: for each element, keeps the hit with the
// greatest time and its list position.
//
// input stream s_*: s_tuser = 0 is a hit, 1 a drain request. a hit whose
// detector differs from detector_select, or whose element or position is
// out of range, is dropped. a hit replaces the kept one when it is the
// first on its element or its time is strictly greater.
// hits are taken one per cycle while no drain runs: the table ram is read on
// accept and written the next cycle, and a write forwards to a following hit
// on the same element. a drain runs group search, bit search with table read
// and result load, and skips the bit search when the table is empty;
// s_tready is low during the drain, so the next request waits until it ends.
// presence bits live in flip-flops in groups of 16, one level a cycle.
// output stream m_*: one request per drain. m_tuser = 0 means the table was
// empty; m_tlast marks that no entry remains. a stalled result sits in the
// output register; hits are still taken, but the next drain holds in its
// last step with s_tready low until the slot frees.
// reset clears all presence bits and detector_select; table data is not
// cleared. config through apb, detector_select at address 0.
`include "assert_macros.svh"

module per_element_latest_hit_select #(
  parameter int NUM_ELEMENTS = pels_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // apb config
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pels_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // hit_detector[7:0], hit_element[15:8], hit_time[31:16], hit_position[43:32]
  input  logic [pels_pkg::S_TDATA_W-1:0]  s_tdata,
  // func[0]
  input  logic [0:0]                      s_tuser,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_element[7:0], out_position[19:8], out_time[35:20]
  output logic [pels_pkg::M_TDATA_W-1:0]  m_tdata,
  // out_valid[0]
  output logic [0:0]                      m_tuser,
  output logic                            m_tlast
);
  import pels_pkg::*;

  localparam int NUM_GROUPS = (NUM_ELEMENTS + GROUP_W - 1) / GROUP_W;
  localparam int GRP_BITS   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int IDX_W      = GRP_BITS + GROUP_BITS;
  localparam int ADDR_W     = $clog2(NUM_ELEMENTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GROUP = 2'd1;
  localparam logic [1:0] S_BIT   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state, state_next;

  // config register
  logic [DET_W-1:0] detector_select;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detector_select <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ADDR_DETECTOR_SELECT) begin
      detector_select <= pwdata[DET_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_DETECTOR_SELECT) ? {24'd0, detector_select} : '0;

  // input fields
  logic [DET_W-1:0]  in_det;
  logic [ELE_W-1:0]  in_ele;
  logic [TIME_W-1:0] in_time;
  logic [POS_W-1:0]  in_pos;
  logic              in_func;
  logic              accept;
  logic              hit_ok;

  assign in_det  = s_tdata[7:0];
  assign in_ele  = s_tdata[15:8];
  assign in_time = s_tdata[31:16];
  assign in_pos  = s_tdata[43:32];
  assign in_func = s_tuser[0];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign hit_ok   = accept && !in_func && (in_det == detector_select) &&
                    ({24'd0, in_ele} < 32'(NUM_ELEMENTS)) &&
                    ({20'd0, in_pos} < 32'(MAX_HITS));

  // hit stage: ram data arrives here
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [TIME_W-1:0] s1_time;
  logic [POS_W-1:0]  s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= hit_ok;
    end
    if (hit_ok) begin
      s1_idx  <= IDX_W'(in_ele);
      s1_time <= in_time;
      s1_pos  <= in_pos;
    end
  end

  // presence bits
  logic [GROUP_W-1:0]    present [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] group_any;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_any[g] = |present[g];
    end
  end

  // table ram
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [MEM_W-1:0]  rd_word;
  logic              wr_en;
  logic [TIME_W-1:0] rd_time;
  logic [POS_W-1:0]  rd_pos;

  assign rd_time = rd_word[TIME_W-1:0];
  assign rd_pos  = rd_word[MEM_W-1:TIME_W];

  // forwarding of the write made in the previous cycle
  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_idx;
  logic [TIME_W-1:0] fwd_time;

  logic [GRP_BITS-1:0]   s1_grp;
  logic [GROUP_BITS-1:0] s1_bit;
  logic                  cur_present;
  logic [TIME_W-1:0]     cur_time;

  assign s1_grp      = s1_idx[IDX_W-1:GROUP_BITS];
  assign s1_bit      = s1_idx[GROUP_BITS-1:0];
  assign cur_present = present[s1_grp][s1_bit];
  assign cur_time    = (fwd_valid && fwd_idx == s1_idx) ? fwd_time : rd_time;
  assign wr_en       = s1_valid && (!cur_present || s1_time > cur_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
    if (wr_en) begin
      fwd_idx  <= s1_idx;
      fwd_time <= s1_time;
    end
  end

  // drain search
  logic [GRP_BITS-1:0]   gidx;
  pick_t                 gpick;
  logic [GROUP_BITS-1:0] bidx;
  pick_t                 bpick;
  logic [GRP_BITS-1:0]   drain_grp;
  logic                  more_groups;
  logic [IDX_W-1:0]      drain_idx;
  logic [IDX_W-1:0]      drain_idx_comb;
  logic                  drain_last;
  logic                  drain_empty;

  pels_pick #(
    .WIDTH (NUM_GROUPS),
    .IDX_W (GRP_BITS)
  ) u_group_pick (
    .vec (group_any),
    .idx (gidx),
    .res (gpick)
  );

  pels_pick #(
    .WIDTH (GROUP_W),
    .IDX_W (GROUP_BITS)
  ) u_bit_pick (
    .vec (present[drain_grp]),
    .idx (bidx),
    .res (bpick)
  );

  assign drain_idx_comb = {drain_grp, bidx};

  assign rd_en   = hit_ok || (state == S_BIT);
  assign rd_addr = hit_ok ? ADDR_W'(IDX_W'(in_ele)) : ADDR_W'(drain_idx_comb);

  pels_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_ELEMENTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(s1_idx)),
    .wdata ({s1_pos, s1_time}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        present[g] <= '0;
      end
    end else begin
      if (wr_en) begin
        present[s1_grp][s1_bit] <= 1'b1;
      end
      if (state == S_BIT) begin
        present[drain_grp][bidx] <= 1'b0;
      end
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && in_func) begin
          state_next = S_GROUP;
        end
      end
      S_GROUP: begin
        state_next = gpick.found ? S_BIT : S_EMIT;
      end
      S_BIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GROUP) begin
      drain_grp   <= gidx;
      more_groups <= gpick.more;
      drain_empty <= !gpick.found;
    end
    if (state == S_BIT) begin
      drain_idx  <= drain_idx_comb;
      drain_last <= !(bpick.more || more_groups);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == S_EMIT && out_free) begin
      m_tuser[0] <= !drain_empty;
      m_tlast    <= drain_empty || drain_last;
      m_tdata    <= drain_empty ? '0 :
                    {4'd0, rd_time, rd_pos, ELE_W'(drain_idx)};
    end
  end

  `ASSERT_IMP(a_hit_only_idle, clk, rst, s1_valid, state == S_IDLE)
  `ASSERT_IMP(a_empty_is_last, clk, rst, m_tvalid && !m_tuser[0], m_tlast)
  `ASSERT_NXT(a_drain_starts, clk, rst, s_tvalid && s_tready && s_tuser[0], state == S_GROUP)
  `ASSERT_NXT(a_emit_waits, clk, rst, state == S_EMIT && m_tvalid && !m_tready, state == S_EMIT)

endmodule
